### sv/periodic_task_release_queue_assert.svh
// Assertion macros shared by the periodic task release queue RTL.
// Needs a clock named aclk and a synchronous active-low reset named aresetn in scope.
`ifndef PERIODIC_TASK_RELEASE_QUEUE_ASSERT_SVH
`define PERIODIC_TASK_RELEASE_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PRTQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/prtq_pkg.sv
// Package for the periodic task release queue: sizes, request/result structs,
// command struct and back-end state type. No dependencies.
package prtq_pkg;

    localparam int TASKS    = 16;
    localparam int MAX_OUT  = 16;
    localparam int TICK_W   = 32;
    localparam int ID_W     = 4;
    localparam int IDX_W    = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int CNT_W    = $clog2(MAX_OUT + 1);
    localparam int SLOT_X_W = 9;   // wide enough for any slot number or TASKS itself
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_REG  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [ID_W-1:0]   task_id;
        logic [TICK_W-1:0] period;
    } in_req_t;

    typedef struct packed {
        logic              released;
        logic [ID_W-1:0]   released_task;
        logic [TICK_W-1:0] next_due;
        logic              last;
    } out_res_t;

    typedef struct packed {
        logic              is_tick;
        logic [IDX_W-1:0]  slot;
        logic [TICK_W-1:0] period;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_PUSH,
        BK_FINAL
    } back_state_t;

    function automatic logic [ID_W-1:0] slot_to_id(input logic [IDX_W-1:0] slot);
        logic [SLOT_X_W-1:0] ext;
        ext = SLOT_X_W'(slot);
        return ext[ID_W-1:0];
    endfunction

endpackage

### sv/prtq_front.sv
// Front end: takes requests, drops register requests that do nothing,
// and hands ticks / table writes to the command queue. Uses prtq_pkg.
module prtq_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  prtq_pkg::in_req_t s_req,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output prtq_pkg::cmd_t    cmd
);

    logic                              cmd_valid_reg, cmd_valid_next;
    prtq_pkg::cmd_t                    cmd_reg, cmd_next;
    logic [prtq_pkg::SLOT_X_W-1:0]     id_ext;
    logic                              keep;
    logic                              accept;

    assign id_ext = prtq_pkg::SLOT_X_W'(s_req.task_id);
    // register request with zero period or a slot beyond the table: it is a no-op
    assign keep = (s_req.op == prtq_pkg::OP_TICK) ||
                  ((s_req.period != '0) &&
                   (id_ext < prtq_pkg::SLOT_X_W'(prtq_pkg::TASKS)));

    assign s_ready = !cmd_valid_reg || cmd_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd_next.is_tick = (s_req.op == prtq_pkg::OP_TICK);
        cmd_next.slot    = id_ext[prtq_pkg::IDX_W-1:0];
        cmd_next.period  = s_req.period;
        if (accept && keep) begin
            cmd_valid_next = 1'b1;
        end else if (cmd_ready) begin
            cmd_valid_next = 1'b0;
        end else begin
            cmd_valid_next = cmd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
        if (accept) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

### sv/prtq_cmd_queue.sv
// Short FIFO of commands between front and back end.
// Uses prtq_pkg for the command type and depth.
module prtq_cmd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  prtq_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output prtq_pkg::cmd_t pop_cmd
);

    prtq_pkg::cmd_t                  mem [prtq_pkg::QDEPTH];
    logic [prtq_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [prtq_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [prtq_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;
    logic                            do_push, do_pop;

    assign push_ready = (cnt_reg != prtq_pkg::QCNT_W'(prtq_pkg::QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_cmd    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### sv/prtq_back.sv
// Back end: task table, tick counter, release scan and the result register.
// Uses prtq_pkg and periodic_task_release_queue_assert.svh.
`include "periodic_task_release_queue_assert.svh"

module prtq_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  prtq_pkg::cmd_t     cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output prtq_pkg::out_res_t m_res
);

    localparam logic [prtq_pkg::IDX_W-1:0] LAST_IDX = prtq_pkg::IDX_W'(prtq_pkg::TASKS - 1);
    localparam logic [prtq_pkg::CNT_W-1:0] CAP_M1   = prtq_pkg::CNT_W'(prtq_pkg::MAX_OUT - 1);

    prtq_pkg::back_state_t             state_reg, state_next;
    logic [prtq_pkg::TICK_W-1:0]       tick_reg, tick_next;
    logic [prtq_pkg::TASKS-1:0]        valid_reg, valid_next;
    logic [prtq_pkg::TASKS-1:0]        done_reg, done_next;
    logic [prtq_pkg::TICK_W-1:0]       due_mem    [prtq_pkg::TASKS];
    logic [prtq_pkg::TICK_W-1:0]       period_mem [prtq_pkg::TASKS];
    logic [prtq_pkg::IDX_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                              found_reg, found_next;
    logic [prtq_pkg::IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [prtq_pkg::TICK_W-1:0]       best_due_reg, best_due_next;
    logic                              pend_valid_reg, pend_valid_next;
    logic [prtq_pkg::IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    logic [prtq_pkg::TICK_W-1:0]       pend_due_reg, pend_due_next;
    logic [prtq_pkg::CNT_W-1:0]        count_reg, count_next;
    logic                              out_valid_reg, out_valid_next;
    prtq_pkg::out_res_t                out_data_reg, out_data_next;

    logic                              pop;
    logic                              out_free;
    logic [prtq_pkg::TICK_W-1:0]       cur_due;
    logic                              cand;
    logic                              take;
    logic                              scan_end;
    logic                              push_go;
    logic [prtq_pkg::TICK_W-1:0]       new_due;
    logic                              due_we;
    logic [prtq_pkg::IDX_W-1:0]        due_waddr;
    logic [prtq_pkg::TICK_W-1:0]       due_wdata;
    logic                              per_we;

    assign cmd_ready = (state_reg == prtq_pkg::BK_IDLE);
    assign pop       = cmd_valid && cmd_ready;
    assign out_free  = !out_valid_reg || m_ready;

    // one table entry examined per cycle
    assign cur_due  = due_mem[scan_idx_reg];
    assign cand     = valid_reg[scan_idx_reg] && !done_reg[scan_idx_reg] && (cur_due <= tick_reg);
    assign take     = cand && (!found_reg || (cur_due < best_due_reg));
    assign scan_end = (scan_idx_reg == LAST_IDX);
    assign push_go  = !pend_valid_reg || out_free;
    assign new_due  = tick_reg + period_mem[best_idx_reg];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            prtq_pkg::BK_IDLE: begin
                if (pop && cmd.is_tick) begin
                    state_next = prtq_pkg::BK_SCAN;
                end
            end
            prtq_pkg::BK_SCAN: begin
                if (scan_end) begin
                    state_next = (found_reg || take) ? prtq_pkg::BK_PUSH : prtq_pkg::BK_FINAL;
                end
            end
            prtq_pkg::BK_PUSH: begin
                if (push_go) begin
                    state_next = (count_reg == CAP_M1) ? prtq_pkg::BK_FINAL
                                                       : prtq_pkg::BK_SCAN;
                end
            end
            prtq_pkg::BK_FINAL: begin
                if (out_free) begin
                    state_next = prtq_pkg::BK_IDLE;
                end
            end
            default: state_next = prtq_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        tick_next       = tick_reg;
        valid_next      = valid_reg;
        done_next       = done_reg;
        scan_idx_next   = scan_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_due_next   = best_due_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_due_next   = pend_due_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_data_next   = out_data_reg;
        due_we          = 1'b0;
        due_waddr       = best_idx_reg;
        due_wdata       = new_due;
        per_we          = 1'b0;
        case (state_reg)
            prtq_pkg::BK_IDLE: begin
                if (pop) begin
                    if (cmd.is_tick) begin
                        tick_next       = tick_reg + 1'b1;
                        done_next       = '0;
                        scan_idx_next   = '0;
                        found_next      = 1'b0;
                        pend_valid_next = 1'b0;
                        count_next      = '0;
                    end else begin
                        valid_next[cmd.slot] = 1'b1;
                        per_we    = 1'b1;
                        due_we    = 1'b1;
                        due_waddr = cmd.slot;
                        due_wdata = tick_reg + cmd.period;
                    end
                end
            end
            prtq_pkg::BK_SCAN: begin
                if (take) begin
                    found_next    = 1'b1;
                    best_idx_next = scan_idx_reg;
                    best_due_next = cur_due;
                end
                scan_idx_next = scan_idx_reg + 1'b1;
            end
            prtq_pkg::BK_PUSH: begin
                if (push_go) begin
                    // earlier release goes out now: another one follows it
                    if (pend_valid_reg) begin
                        out_valid_next              = 1'b1;
                        out_data_next.released      = 1'b1;
                        out_data_next.released_task = prtq_pkg::slot_to_id(pend_idx_reg);
                        out_data_next.next_due      = pend_due_reg;
                        out_data_next.last          = 1'b0;
                    end
                    due_we                 = 1'b1;
                    done_next[best_idx_reg] = 1'b1;
                    pend_valid_next        = 1'b1;
                    pend_idx_next          = best_idx_reg;
                    pend_due_next          = new_due;
                    count_next             = count_reg + 1'b1;
                    scan_idx_next          = '0;
                    found_next             = 1'b0;
                end
            end
            prtq_pkg::BK_FINAL: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next.last = 1'b1;
                    if (pend_valid_reg) begin
                        out_data_next.released      = 1'b1;
                        out_data_next.released_task = prtq_pkg::slot_to_id(pend_idx_reg);
                        out_data_next.next_due      = pend_due_reg;
                    end else begin
                        out_data_next.released      = 1'b0;
                        out_data_next.released_task = '0;
                        out_data_next.next_due      = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= prtq_pkg::BK_IDLE;
            tick_reg       <= '0;
            valid_reg      <= '0;
            done_reg       <= '0;
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            valid_reg      <= valid_next;
            done_reg       <= done_next;
            scan_idx_reg   <= scan_idx_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
        best_idx_reg <= best_idx_next;
        best_due_reg <= best_due_next;
        pend_idx_reg <= pend_idx_next;
        pend_due_reg <= pend_due_next;
        out_data_reg <= out_data_next;
        if (due_we) begin
            due_mem[due_waddr] <= due_wdata;
        end
        if (per_we) begin
            period_mem[cmd.slot] <= cmd.period;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_data_reg;

    `PRTQ_ASSERT_SAME(a_done_matches_count, state_reg == prtq_pkg::BK_SCAN, $countones(done_reg) == count_reg, "done mask out of step with release count")
    `PRTQ_ASSERT_SAME(a_none_is_last, out_valid_reg && !out_data_reg.released, out_data_reg.last, "empty tick result not marked last")
    `PRTQ_ASSERT_NEXT(a_push_waits, state_reg == prtq_pkg::BK_PUSH && pend_valid_reg && !out_free, state_reg == prtq_pkg::BK_PUSH && $stable(best_idx_reg), "release step moved while result stalled")

endmodule

### sv/periodic_task_release_queue.sv
// Top level of the periodic task release queue: front end, command queue, back end.
// Uses prtq_pkg, prtq_front, prtq_cmd_queue and prtq_back.
//
// s_valid/s_ready/s_req carry requests: op = 0 is a tick, op = 1 registers task_id
//   with the given period (period 0 or an out-of-range slot is dropped up front).
// m_valid/m_ready/m_res carry results: one per released task, earliest due first
//   (lower id on ties), last set on the final one; a tick that releases nothing
//   yields one result with released clear and last set. Registers yield none.
// Flow: the front end registers each request and a 4-deep command queue
//   decouples it from the back end, so requests keep flowing while results wait
//   until the queue fills. The back end writes a register request in its idle
//   state. For a tick, the release search walks the table one entry per cycle and
//   is rerun after each release, then a final step emits the last result. A tick
//   that hits the cap of 16 releases skips the last search.
// Reset: aresetn is synchronous, active low. It zeroes the tick counter, marks
//   every slot empty and empties the queue and result register.
// Stall: if m_ready stays low, the back end holds its next release and stops;
//   the queue then fills and s_ready drops.
module periodic_task_release_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  prtq_pkg::in_req_t  s_req,
    output logic               m_valid,
    input  logic               m_ready,
    output prtq_pkg::out_res_t m_res
);

    // front end -> queue
    logic           fq_valid;
    logic           fq_ready;
    prtq_pkg::cmd_t fq_cmd;

    // queue -> back end
    logic           qb_valid;
    logic           qb_ready;
    prtq_pkg::cmd_t qb_cmd;

    prtq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    prtq_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_cmd   (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_cmd    (qb_cmd)
    );

    // back end owns the table, the tick counter and the result register
    prtq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

endmodule
